@@ rtl/rnp_pkg.sv @@
// ============================================================================
// rnp_pkg: shared types and constants of the ringtone note parser
// Payload widths, the event passed from the scanner to the formatter,
// register codes and the tone table.
// ============================================================================
package rnp_pkg;

   // Payload widths
   localparam int CH_W       = 8;
   localparam int FREQ_W     = 15;
   localparam int DUR_W      = 14;
   localparam int LEN_W      = 3;
   localparam int OCT_W      = 3;
   localparam int IDX_W      = 3;
   localparam int TONE_W     = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Result kinds
   localparam logic KIND_NOTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHOLE_NOTE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_OCTAVE = 2'd2;

   // Register reset values
   localparam logic [DUR_W-1:0] WHOLE_NOTE_RESET     = 14'd3809;
   localparam logic [LEN_W-1:0] DEFAULT_LENGTH_RESET = 3'd2;
   localparam logic [OCT_W-1:0] DEFAULT_OCTAVE_RESET = 3'd6;

   // Base tones in tenths of hertz for octave 4: natural, sharp.
   // Row order a..g; the unused eighth row repeats a.
   localparam logic [TONE_W-1:0] NOTE_TONE [8][2] = '{
      '{12'd2200, 12'd2331},
      '{12'd2470, 12'd2616},
      '{12'd1308, 12'd1386},
      '{12'd1468, 12'd1556},
      '{12'd1648, 12'd1746},
      '{12'd1746, 12'd1850},
      '{12'd1960, 12'd2077},
      '{12'd2200, 12'd2331}
   };

   // Scanner states
   typedef enum logic [3:0] {
      SCAN_START,
      SCAN_WAIT,
      SCAN_LEN1,
      SCAN_LEN3,
      SCAN_NOTE,
      SCAN_SHARP,
      SCAN_SCALE,
      SCAN_DOT,
      SCAN_DELIM
   } rnp_scan_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [DUR_W-1:0] whole_note_ms;
      logic [LEN_W-1:0] default_length_log2;
      logic [OCT_W-1:0] default_octave;
   } rnp_csr_type;

   // One queued event: a finished note, an end of melody, or both
   typedef struct packed {
      logic             note_valid;
      logic             end_valid;
      logic             rest;
      logic             sharp;
      logic             dot;
      logic [IDX_W-1:0] note_index;
      logic [1:0]       octave_shift;
      logic [LEN_W-1:0] length_log2;
   } rnp_event_type;

endpackage

@@ rtl/rnp_channels.sv @@
// ============================================================================
// rnp_channels: valid/ready channels of the ringtone note parser
// Request channel carries one melody byte, response channel one result.
// ============================================================================
interface rnp_req_if;
   import rnp_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface rnp_rsp_if;
   import rnp_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [FREQ_W-1:0] freq_decihz;
   logic [DUR_W-1:0]  duration_ms;
   logic              last;

   modport source (output valid, output kind, output freq_decihz, output duration_ms,
                   output last, input ready);
   modport sink   (input valid, input kind, input freq_decihz, input duration_ms,
                   input last, output ready);
endinterface

@@ rtl/rtttl_note_parser_core.sv @@
// ============================================================================
// rtttl_note_parser_core: ringtone note-section parser
// Scans melody bytes, queues finished notes and formats them into
// frequency and duration results.
// ============================================================================
//
//   Channel  Direction  Payload                                     Handshake
//   req_port in         ch[7:0]                                     valid/ready
//   rsp_port out        kind, freq_decihz[14:0], duration_ms[13:0], valid/ready
//                       last
//   csr_*    in         csr_index[1:0], csr_wdata[13:0]             csr_wr_en
//
// One request per cycle; the closing byte's event is registered in the event
// queue and then loaded into the output register. A zero byte that closes a
// note yields two results, the note and then the end marker, limited by the
// single output register. Reset is synchronous and active high; registers
// return to 3809, 2 and 6. Requests stall only when the event queue holds
// QUEUE_DEPTH events, which happens when responses are held back.
//
module rtttl_note_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   rnp_req_if.sink                        req_port,
   rnp_rsp_if.source                      rsp_port,
   input  logic                           csr_wr_en,
   input  logic [rnp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rnp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rnp_pkg::*;

   rnp_csr_type   csr_ff;
   logic          push;
   rnp_event_type push_event;
   logic          pop;
   rnp_event_type head_event;
   logic          head_valid;
   logic          queue_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.whole_note_ms       <= WHOLE_NOTE_RESET;
         csr_ff.default_length_log2 <= DEFAULT_LENGTH_RESET;
         csr_ff.default_octave      <= DEFAULT_OCTAVE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WHOLE_NOTE: begin
               csr_ff.whole_note_ms <= csr_wdata[DUR_W-1:0];
            end
            CSR_DEFAULT_LENGTH: begin
               csr_ff.default_length_log2 <= csr_wdata[LEN_W-1:0];
            end
            CSR_DEFAULT_OCTAVE: begin
               csr_ff.default_octave <= csr_wdata[OCT_W-1:0];
            end
            default: begin
               csr_ff <= csr_ff;
            end
         endcase
      end
   end

   rnp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .csr        (csr_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_event (push_event)
   );

   rnp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head_event (head_event),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   rnp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .head_event (head_event),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_port)
   );

endmodule

@@ rtl/rnp_front.sv @@
// ============================================================================
// rnp_front: byte scanner of the ringtone note parser
// Accepts one melody byte a cycle while the event queue is not full, tracks
// the pending note and pushes an event when a comma or a zero byte closes it.
// ============================================================================
module rnp_front (
   input  logic                   clock,
   input  logic                   reset,
   rnp_req_if.sink                req,
   input  rnp_pkg::rnp_csr_type   csr,
   input  logic                   queue_full,
   output logic                   push,
   output rnp_pkg::rnp_event_type push_event
);
   import rnp_pkg::*;

   // Byte codes
   localparam logic [CH_W-1:0] CHR_NUL     = 8'h00;
   localparam logic [CH_W-1:0] CHR_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CHR_HASH    = 8'h23;
   localparam logic [CH_W-1:0] CHR_COMMA   = 8'h2C;
   localparam logic [CH_W-1:0] CHR_DOT     = 8'h2E;
   localparam logic [CH_W-1:0] CHR_ONE     = 8'h31;
   localparam logic [CH_W-1:0] CHR_TWO     = 8'h32;
   localparam logic [CH_W-1:0] CHR_THREE   = 8'h33;
   localparam logic [CH_W-1:0] CHR_FOUR    = 8'h34;
   localparam logic [CH_W-1:0] CHR_SIX     = 8'h36;
   localparam logic [CH_W-1:0] CHR_SEVEN   = 8'h37;
   localparam logic [CH_W-1:0] CHR_EIGHT   = 8'h38;
   localparam logic [CH_W-1:0] CHR_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CHR_A       = 8'h61;
   localparam logic [CH_W-1:0] CHR_H       = 8'h68;
   localparam logic [CH_W-1:0] CHR_P       = 8'h70;
   localparam logic [CH_W-1:0] CASE_BIT    = 8'h20;

   localparam logic [LEN_W-1:0] LEN_MAX = 3'd5;
   localparam logic [OCT_W-1:0] OCT_MIN = 3'd4;

   rnp_scan_type     state_ff, state_in;
   logic             held_ff, held_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rest_ff, rest_in;
   logic             sharp_ff, sharp_in;
   logic             dot_ff, dot_in;
   logic [OCT_W-1:0] oct_ff, oct_in;
   logic [LEN_W-1:0] len_ff, len_in;

   logic             accept;
   logic [CH_W-1:0]  c;
   logic             is_letter;
   logic             is_term;
   logic             is_skip;
   logic             done;
   logic             restart;
   logic             wait_proc;
   logic             scale_proc;
   logic             letter_proc;
   logic [CH_W-1:0]  letter_off;
   rnp_scan_type     cur;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Fold upper case and classify the byte
   always_comb begin
      c = req.ch;
      if (req.ch >= CHR_UPPER_A && req.ch <= CHR_UPPER_Z) begin
         c = req.ch | CASE_BIT;
      end
      is_letter  = (c >= CHR_A && c <= CHR_H) || c == CHR_P;
      is_term    = c == CHR_NUL || c == CHR_COMMA;
      is_skip    = c <= CHR_SPACE || c[CH_W-1];
      letter_off = c - CHR_A;
   end

   // Next scanner state and note fields for the current byte
   always_comb begin
      state_in    = state_ff;
      held_in     = held_ff;
      idx_in      = idx_ff;
      rest_in     = rest_ff;
      sharp_in    = sharp_ff;
      dot_in      = dot_ff;
      oct_in      = oct_ff;
      len_in      = len_ff;
      done        = 1'b0;
      restart     = 1'b0;
      wait_proc   = 1'b0;
      scale_proc  = 1'b0;
      letter_proc = 1'b0;
      push_event  = '0;

      // Resolve a pending length digit
      if (state_ff == SCAN_LEN1) begin
         state_in = SCAN_NOTE;
         if (c == CHR_SIX) begin
            len_in = 3'd4;
            done   = 1'b1;
         end else begin
            len_in = 3'd0;
         end
      end else if (state_ff == SCAN_LEN3) begin
         if (c == CHR_TWO) begin
            len_in   = 3'd5;
            state_in = SCAN_NOTE;
            done     = 1'b1;
         end else begin
            held_in  = 1'b0;
            state_in = SCAN_START;
         end
      end
      cur = state_in;

      if (!done) begin
         if (is_term) begin
            // Close the pending note, mark end of melody on a zero byte
            push_event.note_valid   = held_ff;
            push_event.end_valid    = c == CHR_NUL;
            push_event.rest         = rest_ff;
            push_event.sharp        = sharp_ff;
            push_event.dot          = dot_ff;
            push_event.note_index   = idx_ff;
            push_event.octave_shift = oct_ff[1:0];
            push_event.length_log2  = len_ff;
            held_in                 = 1'b0;
            state_in                = SCAN_START;
         end else if (!is_skip) begin
            unique case (cur) inside
               SCAN_START, SCAN_DELIM: begin
                  restart = 1'b1;
               end
               SCAN_WAIT: begin
                  wait_proc = 1'b1;
               end
               SCAN_NOTE: begin
                  if (is_letter) begin
                     letter_proc = 1'b1;
                  end else begin
                     held_in  = 1'b0;
                     state_in = SCAN_START;
                  end
               end
               SCAN_SHARP: begin
                  if (c == CHR_HASH) begin
                     sharp_in = 1'b1;
                     state_in = SCAN_SCALE;
                  end else begin
                     scale_proc = 1'b1;
                  end
               end
               SCAN_SCALE: begin
                  scale_proc = 1'b1;
               end
               SCAN_DOT: begin
                  if (c == CHR_DOT) begin
                     dot_in   = 1'b1;
                     state_in = SCAN_DELIM;
                  end else begin
                     restart = 1'b1;
                  end
               end
               default: begin
                  restart = 1'b1;
               end
            endcase

            // Dots and octave digit after the letter
            if (scale_proc) begin
               if (c == CHR_DOT) begin
                  dot_in   = 1'b1;
                  state_in = SCAN_SCALE;
               end else if (c >= CHR_FOUR && c <= CHR_SEVEN) begin
                  oct_in   = c[OCT_W-1:0];
                  state_in = SCAN_DOT;
               end else begin
                  restart = 1'b1;
               end
            end

            // Drop the pending note and load defaults for a new one
            if (restart) begin
               held_in   = 1'b0;
               idx_in    = '0;
               rest_in   = 1'b0;
               sharp_in  = 1'b0;
               dot_in    = 1'b0;
               len_in    = (csr.default_length_log2 > LEN_MAX) ? LEN_MAX
                                                             : csr.default_length_log2;
               oct_in    = (csr.default_octave < OCT_MIN) ? OCT_MIN : csr.default_octave;
               wait_proc = 1'b1;
            end

            // Optional length before the letter
            if (wait_proc) begin
               state_in = SCAN_WAIT;
               case (c)
                  CHR_TWO: begin
                     len_in   = 3'd1;
                     state_in = SCAN_NOTE;
                  end
                  CHR_FOUR: begin
                     len_in   = 3'd2;
                     state_in = SCAN_NOTE;
                  end
                  CHR_EIGHT: begin
                     len_in   = 3'd3;
                     state_in = SCAN_NOTE;
                  end
                  CHR_ONE: begin
                     state_in = SCAN_LEN1;
                  end
                  CHR_THREE: begin
                     state_in = SCAN_LEN3;
                  end
                  default: begin
                     letter_proc = is_letter;
                  end
               endcase
            end

            // Take the note letter
            if (letter_proc) begin
               held_in = 1'b1;
               rest_in = c == CHR_P;
               if (c == CHR_H) begin
                  idx_in = 3'd1;
               end else if (c == CHR_P) begin
                  idx_in = 3'd0;
               end else begin
                  idx_in = letter_off[IDX_W-1:0];
               end
               state_in = (c == CHR_P) ? SCAN_SCALE : SCAN_SHARP;
            end
         end
      end
   end

   assign push = accept && (push_event.note_valid || push_event.end_valid);

   // Scanner state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_START;
         held_ff  <= 1'b0;
         idx_ff   <= '0;
         rest_ff  <= 1'b0;
         sharp_ff <= 1'b0;
         dot_ff   <= 1'b0;
         oct_ff   <= DEFAULT_OCTAVE_RESET;
         len_ff   <= DEFAULT_LENGTH_RESET;
      end else if (accept) begin
         state_ff <= state_in;
         held_ff  <= held_in;
         idx_ff   <= idx_in;
         rest_ff  <= rest_in;
         sharp_ff <= sharp_in;
         dot_ff   <= dot_in;
         oct_ff   <= oct_in;
         len_ff   <= len_in;
      end
   end

endmodule

@@ rtl/rnp_queue.sv @@
// ============================================================================
// rnp_queue: short event queue between scanner and formatter
// Register-based circular buffer; the head entry is visible without delay.
// ============================================================================
module rnp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rnp_pkg::rnp_event_type push_event,
   input  logic                   pop,
   output rnp_pkg::rnp_event_type head_event,
   output logic                   head_valid,
   output logic                   full
);
   import rnp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rnp_event_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_event = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the event
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

@@ rtl/rnp_back.sv @@
// ============================================================================
// rnp_back: result formatter of the ringtone note parser
// Turns queued events into results: tone lookup with octave shift, note
// duration from the whole-note time, and the end-of-melody marker.
// ============================================================================
module rnp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rnp_pkg::rnp_csr_type   csr,
   input  rnp_pkg::rnp_event_type head_event,
   input  logic                   head_valid,
   output logic                   pop,
   rnp_rsp_if.source              rsp
);
   import rnp_pkg::*;

   localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

   logic              valid_ff;
   logic              kind_ff, kind_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic              last_ff, last_in;
   logic              phase_ff, phase_in;

   logic              load;
   logic              emit_note;
   logic [TONE_W-1:0] tone;
   logic [FREQ_W-1:0] note_freq;
   logic [DUR_W-1:0]  dur_base;
   logic [DUR_W:0]    dur_dotted;
   logic [DUR_W-1:0]  note_dur;

   assign load      = head_valid && (!valid_ff || rsp.ready);
   assign emit_note = head_event.note_valid && !phase_ff;

   // Tone and duration of the head note
   always_comb begin
      tone       = NOTE_TONE[head_event.note_index][head_event.sharp];
      note_freq  = head_event.rest ? '0
                                   : FREQ_W'({{(FREQ_W-TONE_W){1'b0}}, tone}
                                             << head_event.octave_shift);
      dur_base   = csr.whole_note_ms >> head_event.length_log2;
      dur_dotted = {1'b0, dur_base} + {2'b00, dur_base[DUR_W-1:1]};
      if (!head_event.dot) begin
         note_dur = dur_base;
      end else if (dur_dotted[DUR_W]) begin
         note_dur = DUR_MAX;
      end else begin
         note_dur = dur_dotted[DUR_W-1:0];
      end
   end

   // Pick the next result: the note first, then the end marker
   always_comb begin
      pop      = 1'b0;
      phase_in = phase_ff;
      kind_in  = KIND_END;
      freq_in  = '0;
      dur_in   = '0;
      last_in  = 1'b1;
      if (emit_note) begin
         kind_in = KIND_NOTE;
         freq_in = note_freq;
         dur_in  = note_dur;
         last_in = !head_event.end_valid;
      end
      if (load) begin
         if (emit_note && head_event.end_valid) begin
            phase_in = 1'b1;
         end else begin
            pop      = 1'b1;
            phase_in = 1'b0;
         end
      end
   end

   // Output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
         phase_ff <= phase_in;
      end
   end

   // Hold the payload until the response is taken
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         freq_ff <= freq_in;
         dur_ff  <= dur_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.freq_decihz = freq_ff;
   assign rsp.duration_ms = dur_ff;
   assign rsp.last        = last_ff;

endmodule
